>>> rtl/gaussian_blur_1d_clamped_edges_core_defines.svh
// Assertion helpers shared by the blur core. They expect clk and arst_n in scope.
`ifndef GAUSSIAN_BLUR_1D_CLAMPED_EDGES_CORE_DEFINES_SVH
`define GAUSSIAN_BLUR_1D_CLAMPED_EDGES_CORE_DEFINES_SVH

`define GBC_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`define GBC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`define GBC_ASSERT_DELAY(label, ante, cycles, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) \
		(ante) |-> ##cycles (cons)) else $error(msg);

`endif

>>> rtl/gbc_pkg.sv
package gbc_pkg;

	localparam int MAX_RADIUS_DEF  = 7;
	localparam int SAMPLE_BITS_DEF = 16;

	localparam int COEFF_BITS      = 16;
	localparam int COEFF_COUNT     = 7;
	localparam int COEFF_FRAC_BITS = 15;
	localparam int RADIUS_BITS     = 3;
	localparam int SEEN_BITS       = 3;
	localparam int CFG_INDEX_BITS  = 3;
	localparam int CFG_DATA_BITS   = 16;
	localparam int QUEUE_DEPTH     = 4;

	localparam logic [SEEN_BITS-1:0]   SEEN_MAX           = 3'd7;
	localparam logic [RADIUS_BITS-1:0] RADIUS_RESET       = 3'd1;
	localparam logic [COEFF_BITS-1:0]  COEFF_CENTER_RESET = 16'h8000;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_KERNEL_RADIUS = 3'd0,
		REG_COEFF_CENTER  = 3'd1,
		REG_COEFF_DIST1   = 3'd2,
		REG_COEFF_DIST2   = 3'd3,
		REG_COEFF_DIST3   = 3'd4,
		REG_COEFF_DIST4   = 3'd5,
		REG_COEFF_DIST5   = 3'd6,
		REG_COEFF_DIST6   = 3'd7
	} cfg_reg_t;

	typedef struct packed {
		logic [RADIUS_BITS-1:0]                radius;
		logic [COEFF_COUNT-1:0][COEFF_BITS-1:0] coeff;
	} gbc_cfg_t;

	typedef struct packed {
		logic                 first;
		logic                 last;
		logic [SEEN_BITS-1:0] count;
	} item_ctrl_t;

endpackage

>>> rtl/gbc_if.sv
interface gbc_in_if #(
	parameter int SAMPLE_BITS = gbc_pkg::SAMPLE_BITS_DEF
) ();
	logic                   valid;
	logic                   ready;
	logic [SAMPLE_BITS-1:0] sample;
	logic                   last_sample;

	modport source (output valid, sample, last_sample, input ready);
	modport sink (input valid, sample, last_sample, output ready);
endinterface

interface gbc_out_if #(
	parameter int SAMPLE_BITS = gbc_pkg::SAMPLE_BITS_DEF
) ();
	logic                   valid;
	logic                   ready;
	logic [SAMPLE_BITS-1:0] blurred;
	logic                   last_result;

	modport source (output valid, blurred, last_result, input ready);
	modport sink (input valid, blurred, last_result, output ready);
endinterface

>>> rtl/gbc_fifo.sv
module gbc_fifo #(
	parameter int WIDTH = gbc_pkg::SAMPLE_BITS_DEF + $bits(gbc_pkg::item_ctrl_t),
	parameter int DEPTH = gbc_pkg::QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] pop_data,
	output logic             empty
);
	localparam int PTR_BITS   = $clog2(DEPTH);
	localparam int COUNT_BITS = $clog2(DEPTH + 1);

	logic [WIDTH-1:0]      entry_q [DEPTH];
	logic [PTR_BITS-1:0]   wr_ptr_q;
	logic [PTR_BITS-1:0]   rd_ptr_q;
	logic [COUNT_BITS-1:0] count_q;
	logic                  do_push;
	logic                  do_pop;

	assign full     = (count_q == COUNT_BITS'(DEPTH));
	assign empty    = (count_q == '0);
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign pop_data = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

>>> rtl/gbc_front.sv
module gbc_front #(
	parameter int SAMPLE_BITS = gbc_pkg::SAMPLE_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	gbc_in_if.sink samples,
	input  logic queue_full,
	output logic queue_push,
	output logic [SAMPLE_BITS+$bits(gbc_pkg::item_ctrl_t)-1:0] queue_data
);
	import gbc_pkg::*;

	logic [SEEN_BITS-1:0] seen_q;
	logic [SEEN_BITS-1:0] count_next;
	item_ctrl_t           ctrl;

	assign samples.ready = !queue_full;
	assign queue_push    = samples.valid && !queue_full;

	// The running count saturates; zero marks the start of a new sequence.
	assign count_next = (seen_q == SEEN_MAX) ? SEEN_MAX : seen_q + 1'b1;

	always_comb begin
		ctrl.first = (seen_q == '0);
		ctrl.last  = samples.last_sample;
		ctrl.count = count_next;
	end

	assign queue_data = {samples.sample, ctrl};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= '0;
		end else if (queue_push) begin
			seen_q <= samples.last_sample ? '0 : count_next;
		end
	end

endmodule

>>> rtl/gbc_back.sv
`include "gaussian_blur_1d_clamped_edges_core_defines.svh"

module gbc_back #(
	parameter int MAX_RADIUS  = gbc_pkg::MAX_RADIUS_DEF,
	parameter int SAMPLE_BITS = gbc_pkg::SAMPLE_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  gbc_pkg::gbc_cfg_t cfg,
	input  logic queue_empty,
	input  logic [SAMPLE_BITS+$bits(gbc_pkg::item_ctrl_t)-1:0] queue_data,
	output logic queue_pop,
	gbc_out_if.source results
);
	import gbc_pkg::*;

	localparam int WINDOW_DEPTH = 2 * MAX_RADIUS - 1;
	localparam int TAP_BITS     = $clog2(WINDOW_DEPTH + 1);
	localparam int PROD_BITS    = SAMPLE_BITS + COEFF_BITS;
	localparam int ACC_BITS     = PROD_BITS + $clog2(WINDOW_DEPTH + 1);
	localparam int ROUND_BITS   = ACC_BITS + 1;
	localparam int SCALED_BITS  = ROUND_BITS - COEFF_FRAC_BITS;
	localparam logic [ROUND_BITS-1:0] ROUND_BIAS = ROUND_BITS'(1) << (COEFF_FRAC_BITS - 1);

	typedef enum logic [5:0] {
		ST_IDLE   = 6'b000001,
		ST_DECIDE = 6'b000010,
		ST_MAC    = 6'b000100,
		ST_DRAIN  = 6'b001000,
		ST_EMIT   = 6'b010000,
		ST_NEXT   = 6'b100000
	} state_t;

	state_t                 state_q;
	logic [SAMPLE_BITS-1:0] window_q [WINDOW_DEPTH];
	logic [SAMPLE_BITS-1:0] work_q [WINDOW_DEPTH];
	logic [SAMPLE_BITS-1:0] sample_q;
	item_ctrl_t             ctrl_q;
	logic [RADIUS_BITS-1:0] step_q;
	logic                   final_q;
	logic [TAP_BITS-1:0]    tap_q;
	logic [PROD_BITS-1:0]   prod_s1;
	logic [ACC_BITS-1:0]    acc_q;
	logic                   out_valid_q;
	logic                   out_last_q;
	logic [SAMPLE_BITS-1:0] out_data_q;

	logic [SAMPLE_BITS-1:0] head_sample;
	item_ctrl_t             head_ctrl;
	logic                   emit_now;
	logic                   step_final;
	logic                   out_load;
	logic                   emit_last;
	logic [TAP_BITS-1:0]    last_tap;
	logic [4:0]             tap_w;
	logic [4:0]             center_w;
	logic [4:0]             dist_w;
	logic [RADIUS_BITS-1:0] tap_dist;
	logic [ROUND_BITS-1:0]  round_sum;
	logic [SCALED_BITS-1:0] scaled;
	logic [SAMPLE_BITS-1:0] sat_value;

	assign {head_sample, head_ctrl} = queue_data;
	assign queue_pop = (state_q == ST_IDLE) && !queue_empty;

	// Step zero is the item itself; a closing item adds R-1 steps that repeat its sample.
	assign emit_now   = ({1'b0, ctrl_q.count} + {1'b0, step_q}) >= {1'b0, cfg.radius};
	assign step_final = !ctrl_q.last || (({1'b0, step_q} + 4'd1) >= {1'b0, cfg.radius});
	assign emit_last  = ctrl_q.last && final_q;

	assign last_tap = TAP_BITS'({2'b00, cfg.radius, 1'b0} - 6'd2);
	assign tap_w    = 5'(tap_q);
	assign center_w = 5'(cfg.radius) - 5'd1;
	assign dist_w   = (tap_w >= center_w) ? tap_w - center_w : center_w - tap_w;
	assign tap_dist = dist_w[RADIUS_BITS-1:0];

	assign round_sum = ROUND_BITS'(acc_q) + ROUND_BIAS;
	assign scaled    = round_sum[ROUND_BITS-1:COEFF_FRAC_BITS];
	assign sat_value = (|scaled[SCALED_BITS-1:SAMPLE_BITS]) ? '1 : scaled[SAMPLE_BITS-1:0];

	assign out_load = (state_q == ST_EMIT) && (!out_valid_q || results.ready);

	assign results.valid       = out_valid_q;
	assign results.blurred     = out_data_q;
	assign results.last_result = out_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= '0;
			final_q     <= 1'b0;
			tap_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (!queue_empty) begin
						step_q  <= '0;
						state_q <= ST_DECIDE;
					end
				end
				ST_DECIDE: begin
					final_q <= step_final;
					if (emit_now) begin
						tap_q   <= '0;
						state_q <= ST_MAC;
					end else begin
						state_q <= ST_NEXT;
					end
				end
				ST_MAC: begin
					tap_q <= tap_q + 1'b1;
					if (tap_q == last_tap) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (out_load) begin
						state_q <= ST_NEXT;
					end
				end
				ST_NEXT: begin
					if (final_q) begin
						state_q <= ST_IDLE;
					end else begin
						step_q  <= step_q + 1'b1;
						state_q <= ST_DECIDE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (queue_pop) begin
			sample_q <= head_sample;
			ctrl_q   <= head_ctrl;
			if (head_ctrl.first) begin
				for (int i = 0; i < WINDOW_DEPTH; i++) begin
					window_q[i] <= head_sample;
				end
			end else begin
				for (int i = WINDOW_DEPTH - 1; i > 0; i--) begin
					window_q[i] <= window_q[i-1];
				end
				window_q[0] <= head_sample;
			end
		end

		if ((state_q == ST_NEXT) && !final_q) begin
			for (int i = WINDOW_DEPTH - 1; i > 0; i--) begin
				window_q[i] <= window_q[i-1];
			end
			window_q[0] <= sample_q;
		end

		if ((state_q == ST_DECIDE) && emit_now) begin
			work_q <= window_q;
			acc_q  <= '0;
		end

		// Taps leave the snapshot one per cycle, newest first.
		if (state_q == ST_MAC) begin
			prod_s1 <= PROD_BITS'(work_q[0]) * PROD_BITS'(cfg.coeff[tap_dist]);
			for (int i = 0; i < WINDOW_DEPTH - 1; i++) begin
				work_q[i] <= work_q[i+1];
			end
			work_q[WINDOW_DEPTH-1] <= '0;
			if (tap_q != '0) begin
				acc_q <= acc_q + ACC_BITS'(prod_s1);
			end
		end

		if (state_q == ST_DRAIN) begin
			acc_q <= acc_q + ACC_BITS'(prod_s1);
		end

		if (out_load) begin
			out_data_q <= sat_value;
			out_last_q <= emit_last;
		end
	end

	`GBC_ASSERT_NEXT(a_mac_ends, (state_q == ST_MAC) && (tap_q == last_tap),
		state_q == ST_DRAIN, "tap walk did not stop at the outer tap")
	`GBC_ASSERT_IMPL(a_load_in_emit, $rose(out_valid_q), $past(state_q) == ST_EMIT,
		"result register loaded outside the emit state")
	`GBC_ASSERT_DELAY(a_last_closes, out_load && emit_last, 2, state_q == ST_IDLE,
		"closing result did not end the item")

endmodule

>>> rtl/gaussian_blur_1d_clamped_edges_core.sv
// Symmetric blur of a sample stream with replicated borders. Samples enter on the samples
// channel, the final one of a sequence marked by last_sample; each result leaves on the
// results channel once the sample R-1 places after its center has arrived, and the closing
// sample flushes the rest with last_result on the final one. Software loads the radius and
// the Q1.15 weights through the write port while the block is idle. Input transfers go into
// a four-entry queue, so the stream is taken at one sample per cycle until it fills. One
// shared multiplier walks the 2R-1 taps: an item leaves the queue in the idle state, then
// each step passes the decide state and, when it yields a result, the tap walk, drain and
// emit states, where a held result waits on the sink, before the next state. A closing
// sample runs R steps, any other sample one. Nothing needs a clearing pass after reset.
module gaussian_blur_1d_clamped_edges_core #(
	parameter int MAX_RADIUS  = gbc_pkg::MAX_RADIUS_DEF,
	parameter int SAMPLE_BITS = gbc_pkg::SAMPLE_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	gbc_in_if.sink samples,
	gbc_out_if.source results,
	input  logic cfg_wr_en,
	input  logic [gbc_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [gbc_pkg::CFG_DATA_BITS-1:0] cfg_data
);
	import gbc_pkg::*;

	localparam int QUEUE_BITS = SAMPLE_BITS + $bits(item_ctrl_t);

	logic [RADIUS_BITS-1:0]                radius_q;
	logic [COEFF_COUNT-1:0][COEFF_BITS-1:0] coeff_q;
	gbc_cfg_t                              cfg;
	logic                                  queue_push;
	logic                                  queue_full;
	logic                                  queue_pop;
	logic                                  queue_empty;
	logic [QUEUE_BITS-1:0]                 push_data;
	logic [QUEUE_BITS-1:0]                 pop_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= RADIUS_RESET;
			coeff_q  <= {{((COEFF_COUNT - 1) * COEFF_BITS){1'b0}}, COEFF_CENTER_RESET};
		end else if (cfg_wr_en) begin
			if (cfg_index == REG_KERNEL_RADIUS) begin
				radius_q <= cfg_data[RADIUS_BITS-1:0];
			end else begin
				coeff_q[CFG_INDEX_BITS'(cfg_index - REG_COEFF_CENTER)] <= cfg_data[COEFF_BITS-1:0];
			end
		end
	end

	// A radius of zero acts as a single tap; values above MAX_RADIUS clamp to MAX_RADIUS.
	always_comb begin
		if (radius_q == '0) begin
			cfg.radius = RADIUS_BITS'(1);
		end else if (radius_q > RADIUS_BITS'(MAX_RADIUS)) begin
			cfg.radius = RADIUS_BITS'(MAX_RADIUS);
		end else begin
			cfg.radius = radius_q;
		end
		cfg.coeff = coeff_q;
	end

	gbc_front #(
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.samples    (samples),
		.queue_full (queue_full),
		.queue_push (queue_push),
		.queue_data (push_data)
	);

	gbc_fifo #(
		.WIDTH (QUEUE_BITS),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (queue_push),
		.push_data (push_data),
		.full      (queue_full),
		.pop       (queue_pop),
		.pop_data  (pop_data),
		.empty     (queue_empty)
	);

	gbc_back #(
		.MAX_RADIUS  (MAX_RADIUS),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.queue_empty (queue_empty),
		.queue_data  (pop_data),
		.queue_pop   (queue_pop),
		.results     (results)
	);

endmodule

>>> verif/gaussian_blur_1d_clamped_edges_core_test.sv
`timescale 1ns / 1ps

module gaussian_blur_1d_clamped_edges_core_test;
	import gbc_pkg::*;

	localparam int SAMPLE_BITS  = SAMPLE_BITS_DEF;
	localparam int MAX_RADIUS   = MAX_RADIUS_DEF;
	localparam int WINDOW_DEPTH = 2 * MAX_RADIUS - 1;
	localparam logic [SAMPLE_BITS-1:0] SAMPLE_TOP = '1;

	typedef struct {
		logic [SAMPLE_BITS-1:0] blurred;
		logic                   last_result;
	} blur_result_t;

	logic clk;
	logic arst_n;
	logic cfg_wr_en;
	logic [CFG_INDEX_BITS-1:0] cfg_index;
	logic [CFG_DATA_BITS-1:0] cfg_data;

	gbc_in_if #(.SAMPLE_BITS(SAMPLE_BITS)) samples_ch ();
	gbc_out_if #(.SAMPLE_BITS(SAMPLE_BITS)) results_ch ();

	gaussian_blur_1d_clamped_edges_core #(
		.MAX_RADIUS(MAX_RADIUS),
		.SAMPLE_BITS(SAMPLE_BITS)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.samples(samples_ch),
		.results(results_ch),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	logic [RADIUS_BITS-1:0] radius_q;
	logic [COEFF_BITS-1:0] coeff_q [COEFF_COUNT];
	logic [SAMPLE_BITS-1:0] window_q [WINDOW_DEPTH];
	logic [SEEN_BITS-1:0] seen_q;
	blur_result_t pending_blurs [$];
	int unsigned mismatch_count = 0;
	int unsigned send_gap_pct;
	int unsigned sink_stall_pct;

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic void shift_window(logic [SAMPLE_BITS-1:0] s);
		for (int i = WINDOW_DEPTH - 1; i > 0; i--) begin
			window_q[i] = window_q[i-1];
		end
		window_q[0] = s;
	endfunction

	function automatic logic [SAMPLE_BITS-1:0] blur_window(int unsigned r);
		logic [63:0] acc;
		int unsigned d;
		acc = '0;
		for (int unsigned j = 0; j + 1 < 2 * r; j++) begin
			d = (j >= r - 1) ? j - (r - 1) : (r - 1) - j;
			acc += 64'(window_q[j]) * 64'(coeff_q[d]);
		end
		acc = (acc + 64'd16384) >> COEFF_FRAC_BITS;
		return (acc > 64'(SAMPLE_TOP)) ? SAMPLE_TOP : acc[SAMPLE_BITS-1:0];
	endfunction

	function automatic void blur_sample(logic [SAMPLE_BITS-1:0] s, logic last);
		int unsigned r;
		int unsigned k;
		int unsigned n;
		blur_result_t res;
		r = (radius_q == 0) ? 1 : radius_q;
		if (r > MAX_RADIUS) begin
			r = MAX_RADIUS;
		end
		k = seen_q + 1;
		if (k > SEEN_MAX) begin
			k = SEEN_MAX;
		end
		if (seen_q == 0) begin
			foreach (window_q[i]) window_q[i] = s;
		end else begin
			shift_window(s);
		end
		n = 0;
		if (k >= r) begin
			res.blurred = blur_window(r);
			res.last_result = 1'b0;
			pending_blurs.push_back(res);
			n++;
		end
		if (last) begin
			for (int unsigned i = 1; i < r; i++) begin
				shift_window(s);
				if (k + i >= r) begin
					res.blurred = blur_window(r);
					res.last_result = 1'b0;
					pending_blurs.push_back(res);
					n++;
				end
			end
			if (n > 0) begin
				pending_blurs[$].last_result = 1'b1;
			end
			seen_q = '0;
		end else begin
			seen_q = k[SEEN_BITS-1:0];
		end
	endfunction

	task automatic report_mismatch(string what);
		$display("%0t: mismatch: %s", $time, what);
		mismatch_count++;
	endtask

	always @(negedge clk) begin
		results_ch.ready <= ($urandom_range(0, 99) >= sink_stall_pct);
	end

	always @(posedge clk) begin
		blur_result_t want;
		if (arst_n && results_ch.valid && results_ch.ready) begin
			if (pending_blurs.size() == 0) begin
				report_mismatch($sformatf("unexpected result blurred=%0d last_result=%0b",
					results_ch.blurred, results_ch.last_result));
			end else begin
				want = pending_blurs.pop_front();
				if (results_ch.blurred !== want.blurred) begin
					report_mismatch($sformatf("blurred %0d, wanted %0d",
						results_ch.blurred, want.blurred));
				end
				if (results_ch.last_result !== want.last_result) begin
					report_mismatch($sformatf("last_result %0b, wanted %0b",
						results_ch.last_result, want.last_result));
				end
			end
		end
	end

	// Called at a falling edge; returns at the falling edge after the transfer.
	task automatic send_sample(logic [SAMPLE_BITS-1:0] s, logic last);
		while ($urandom_range(0, 99) < send_gap_pct) begin
			samples_ch.valid = 1'b0;
			@(negedge clk);
		end
		samples_ch.valid = 1'b1;
		samples_ch.sample = s;
		samples_ch.last_sample = last;
		do begin
			@(posedge clk);
		end while (!samples_ch.ready);
		blur_sample(s, last);
		@(negedge clk);
	endtask

	// Samples that yield no result may still sit in the input queue, so allow them to retire.
	task automatic wait_idle();
		samples_ch.valid = 1'b0;
		while (pending_blurs.size() != 0) begin
			@(posedge clk);
		end
		repeat (40) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_BITS-1:0] value);
		cfg_wr_en = 1'b1;
		cfg_index = idx;
		cfg_data = value;
		if (idx == REG_KERNEL_RADIUS) begin
			radius_q = value[RADIUS_BITS-1:0];
		end else begin
			coeff_q[idx - REG_COEFF_CENTER] = value[COEFF_BITS-1:0];
		end
		@(negedge clk);
		cfg_wr_en = 1'b0;
	endtask

	function automatic logic [COEFF_BITS-1:0] random_coeff();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return 16'h8000;
			2: return 16'hFFFF;
			default: return COEFF_BITS'($urandom_range(0, 8192));
		endcase
	endfunction

	function automatic logic [SAMPLE_BITS-1:0] random_sample();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return SAMPLE_TOP;
			default: return SAMPLE_BITS'($urandom());
		endcase
	endfunction

	task automatic load_random_kernel();
		write_reg(REG_KERNEL_RADIUS, CFG_DATA_BITS'($urandom_range(0, 7)));
		for (int i = REG_COEFF_CENTER; i <= REG_COEFF_DIST6; i++) begin
			write_reg(cfg_reg_t'(i), random_coeff());
		end
	endtask

	task automatic test_default_kernel();
		send_sample('0, 1'b0);
		send_sample(SAMPLE_TOP, 1'b0);
		send_sample(16'h5A5A, 1'b1);
		send_sample(16'hA5A5, 1'b1);
		wait_idle();
	endtask

	task automatic test_radius_zero();
		write_reg(REG_KERNEL_RADIUS, 16'd0);
		write_reg(REG_COEFF_CENTER, 16'h8000);
		send_sample(16'h1234, 1'b0);
		send_sample(SAMPLE_TOP, 1'b1);
		wait_idle();
	endtask

	task automatic test_widest_kernel();
		write_reg(REG_KERNEL_RADIUS, 16'(MAX_RADIUS));
		write_reg(REG_COEFF_CENTER, 16'd8192);
		write_reg(REG_COEFF_DIST1, 16'd4096);
		write_reg(REG_COEFF_DIST2, 16'd4096);
		write_reg(REG_COEFF_DIST3, 16'd4096);
		write_reg(REG_COEFF_DIST4, 16'd2048);
		write_reg(REG_COEFF_DIST5, 16'd0);
		write_reg(REG_COEFF_DIST6, 16'hFFFF);
		send_sample(SAMPLE_TOP, 1'b0);
		send_sample('0, 1'b0);
		send_sample('0, 1'b0);
		send_sample(SAMPLE_TOP, 1'b0);
		send_sample(16'h8000, 1'b0);
		send_sample(16'h7FFF, 1'b0);
		send_sample(16'h0001, 1'b0);
		send_sample(16'hFFFE, 1'b0);
		send_sample(SAMPLE_TOP, 1'b1);
		wait_idle();
		write_reg(REG_COEFF_DIST6, 16'd1024);
		send_sample(16'd100, 1'b0);
		send_sample(16'd200, 1'b0);
		send_sample(16'd300, 1'b1);
		wait_idle();
	endtask

	task automatic test_radius_change_mid_sequence();
		write_reg(REG_KERNEL_RADIUS, 16'd3);
		send_sample(16'd1000, 1'b0);
		send_sample(16'd40000, 1'b0);
		send_sample(16'd7, 1'b0);
		wait_idle();
		write_reg(REG_KERNEL_RADIUS, 16'd5);
		send_sample(16'd65000, 1'b0);
		send_sample(16'd12345, 1'b1);
		wait_idle();
	endtask

	task automatic test_random_streams(int unsigned gap_pct, int unsigned stall_pct,
		int unsigned item_count);
		int unsigned sent;
		int unsigned len;
		send_gap_pct = gap_pct;
		sink_stall_pct = stall_pct;
		sent = 0;
		while (sent < item_count) begin
			if (sent == 0 || $urandom_range(0, 3) == 0) begin
				wait_idle();
				load_random_kernel();
			end
			len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 12);
			for (int unsigned i = 0; i < len; i++) begin
				send_sample(random_sample(), i == len - 1);
			end
			sent += len;
		end
		wait_idle();
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = REG_KERNEL_RADIUS;
		cfg_data = '0;
		samples_ch.valid = 1'b0;
		samples_ch.sample = '0;
		samples_ch.last_sample = 1'b0;
		send_gap_pct = 0;
		sink_stall_pct = 0;
		radius_q = RADIUS_RESET;
		coeff_q[0] = COEFF_CENTER_RESET;
		for (int i = 1; i < COEFF_COUNT; i++) begin
			coeff_q[i] = '0;
		end
		foreach (window_q[i]) window_q[i] = '0;
		seen_q = '0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_default_kernel();
		test_radius_zero();
		test_widest_kernel();
		test_radius_change_mid_sequence();
		test_random_streams(0, 0, 105);
		test_random_streams(59, 0, 105);
		test_random_streams(0, 59, 105);
		test_random_streams(33, 33, 105);

		if (mismatch_count == 0) begin
			$display("gaussian_blur_1d_clamped_edges_core_test: clean");
		end else begin
			$display("gaussian_blur_1d_clamped_edges_core_test: errors");
		end
		$finish;
	end

	initial begin
		#10_000_000;
		$display("%0t: timeout, %0d results still outstanding", $time, pending_blurs.size());
		$display("gaussian_blur_1d_clamped_edges_core_test: errors");
		$finish;
	end

endmodule
